>>> sv/bct_pkg.sv
// Shared widths, constants and divider request types for the Bezier tessellator.
// Used by bct_div and bezier_curve_tessellator; depends on nothing.
`default_nettype none

package bct_pkg;

  // Field and register widths
  localparam int CoordW   = 16;                  // control and curve coordinates
  localparam int IdxInW   = 4;                   // point_index field
  localparam int NptW     = 5;                   // num_points register
  localparam int SegW     = 6;                   // segments register
  localparam int FracW    = 16;                  // fraction bits of t
  localparam int TW       = FracW + 1;           // t spans 0 .. 1.0 inclusive
  localparam int DivW     = SegW + FracW;        // dividend i << FracW
  localparam int ProdW    = TW + 1 + CoordW + 1; // signed t times coordinate difference
  localparam int PointW   = 2 * CoordW;          // packed {y, x}

  // Stream and configuration port widths
  localparam int InDataW  = 40;                  // index, x, y padded to whole bytes
  localparam int OutDataW = 32;                  // x, y
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  // Rounding constant of one lerp: one half in units of t
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(2 ** (FracW - 1));

  // Divider request and response
  typedef struct packed {
    logic            start;
    logic [SegW-1:0] num;   // i; the dividend is i << FracW
    logic [SegW-1:0] den;   // segments
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [TW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/bezier_curve_tessellator.sv
// Top level of the Bezier tessellator: control point store, de Casteljau sequencer
// around one shared multiplier, output register. Depends on bct_pkg and bct_div.
//
// Usage: set num_points (index 0) and segments (index 1) on the cfg channel while
// the block is idle. Requests on the s_axis channel carry a kind in tuser: a write
// request stores one control point (x, y) at point_index and emits nothing; a
// generate request emits segments+1 curve points on m_axis, tlast on the final one.
// Zero points or zero segments emit nothing. A write request leaves the block idle.
// Each curve point first runs the serial divider for t, then de Casteljau rounds
// over the control store and a scratch store: each round primes the operands in
// states RS0, RS1 and RS2, and each lerp runs through MX, MY and WR, since x and
// y share the one multiplier. The point then leaves through the emit state; a
// single point skips RS2 and the lerps.
// s_axis_tready_o is low while a generate request is being worked on.
// Results leave through one output register; when m_axis stalls, the sequencer
// holds its finished point until the register frees. The last point may wait there
// while the next request is already taken.
// Reset clears the configuration registers and the control flow; the datapath
// registers and the control point store hold nothing defined until written.
`default_nettype none

module bezier_curve_tessellator #(
  parameter int MAX_POINTS = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Configuration write channel
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [bct_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [bct_pkg::CfgDataW-1:0]    cfg_data_i,
  // Request stream
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: point_index [3:0], point_x [19:4], point_y [35:20], zero [39:36]
  input  wire  [bct_pkg::InDataW-1:0]     s_axis_tdata_i,
  // tuser: action [0]
  input  wire  [0:0]                      s_axis_tuser_i,
  // Curve point stream
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // tdata: curve_x [15:0], curve_y [31:16]
  output logic [bct_pkg::OutDataW-1:0]    m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import bct_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);

  // Request kinds and register indexes
  localparam logic                ActWrite     = 1'b0;
  localparam logic                ActGen       = 1'b1;
  localparam logic [CfgIdxW-1:0]  CfgNumPoints = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0]  CfgSegments  = CfgIdxW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_RS0,
    S_RS1,
    S_RS2,
    S_MX,
    S_MY,
    S_WR,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [NptW-1:0]   num_points_q;
  logic [SegW-1:0]   segments_q;
  logic [SegW-1:0]   i_q;
  logic [IdxW-1:0]   len_q;       // lerps in the current round
  logic [IdxW-1:0]   k_q;         // lerp within the round
  logic              src_ctrl_q;  // round reads the control store
  logic              m_valid_q;
  logic              m_last_q;

  logic [TW-1:0]            t_q;
  logic [PointW-1:0]        a_q;
  logic [PointW-1:0]        b_q;
  logic signed [ProdW-1:0]  prod_q;
  logic [CoordW-1:0]        rx_q;
  logic [PointW-1:0]        res_q;
  logic [OutDataW-1:0]      m_data_q;

  logic [PointW-1:0]  ctrl_mem [MAX_POINTS];
  logic [PointW-1:0]  work_mem [MAX_POINTS];
  logic [PointW-1:0]  ctrl_rd_q;
  logic [PointW-1:0]  work_rd_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Request decode
  logic               in_acc;
  logic               in_action;
  logic [IdxInW-1:0]  in_idx;
  logic [CoordW-1:0]  in_x;
  logic [CoordW-1:0]  in_y;
  logic [CntW-1:0]    n_eff;
  logic [IdxW-1:0]    len_init;
  logic               gen_ok;
  logic               ctrl_we;
  logic               out_free;
  logic               last_pt;
  logic [IdxW-1:0]    rd_addr;
  logic [PointW-1:0]  rdata;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_action       = s_axis_tuser_i[0];
  assign in_idx          = s_axis_tdata_i[IdxInW-1:0];
  assign in_x            = s_axis_tdata_i[IdxInW +: CoordW];
  assign in_y            = s_axis_tdata_i[IdxInW + CoordW +: CoordW];

  // Clamp the point count to the store depth
  always_comb begin
    if (32'(num_points_q) > MAX_POINTS) begin
      n_eff = CntW'(MAX_POINTS);
    end else begin
      n_eff = CntW'(num_points_q);
    end
  end

  assign len_init = IdxW'(n_eff - CntW'(1));
  assign gen_ok   = (in_action == ActGen) && (n_eff != '0) && (segments_q != '0);
  assign ctrl_we  = in_acc && (in_action == ActWrite) && (32'(in_idx) < MAX_POINTS);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign last_pt  = (i_q == segments_q);

  // Start t for point 0 on a generate request, for the next point on emit
  always_comb begin
    div_req.start = (in_acc && gen_ok) || (state_q == S_EMIT && out_free && !last_pt);
    div_req.num   = (state_q == S_EMIT) ? (i_q + SegW'(1)) : '0;
    div_req.den   = segments_q;
  end

  bct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Store read address: a first, b first, then the next b during a lerp
  always_comb begin
    unique case (state_q)
      S_RS0:   rd_addr = '0;
      S_RS1:   rd_addr = IdxW'(1);
      S_MY:    rd_addr = IdxW'(32'(k_q) + 2);
      default: rd_addr = '0;
    endcase
  end

  assign rdata = src_ctrl_q ? ctrl_rd_q : work_rd_q;

  // Control point store
  always_ff @(posedge clk_i) begin
    if (ctrl_we) begin
      ctrl_mem[IdxW'(in_idx)] <= {in_y, in_x};
    end
    ctrl_rd_q <= ctrl_mem[rd_addr];
  end

  // Shared lerp datapath: one multiplier, one rounding adder
  logic signed [CoordW-1:0]  ax, ay, bx, by;
  logic signed [CoordW:0]    diff;
  logic signed [ProdW-1:0]   mul;
  logic signed [ProdW-1:0]   rnd_sum;
  logic signed [ProdW-1:0]   rnd_shift;
  logic [CoordW-1:0]         lerp_a;
  logic [CoordW-1:0]         lerp;

  assign ax = a_q[CoordW-1:0];
  assign ay = a_q[PointW-1:CoordW];
  assign bx = b_q[CoordW-1:0];
  assign by = b_q[PointW-1:CoordW];

  always_comb begin
    if (state_q == S_MX) begin
      diff = {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
    end else begin
      diff = {by[CoordW-1], by} - {ay[CoordW-1], ay};
    end
    mul       = $signed({1'b0, t_q}) * diff;
    rnd_sum   = prod_q + RoundHalf;
    rnd_shift = rnd_sum >>> FracW;
    lerp_a    = (state_q == S_MY) ? ax : ay;
    lerp      = lerp_a + rnd_shift[CoordW-1:0];
  end

  // Scratch store of the de Casteljau pyramid
  always_ff @(posedge clk_i) begin
    if (state_q == S_WR) begin
      work_mem[k_q] <= {lerp, rx_q};
    end
    work_rd_q <= work_mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= '0;
      segments_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgNumPoints) begin
        num_points_q <= cfg_data_i[NptW-1:0];
      end else if (cfg_index_i == CfgSegments) begin
        segments_q <= cfg_data_i[SegW-1:0];
      end
    end
  end

  // Sequencer and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      i_q        <= '0;
      len_q      <= '0;
      k_q        <= '0;
      src_ctrl_q <= 1'b1;
      m_valid_q  <= 1'b0;
      m_last_q   <= 1'b0;
    end else begin
      // drop the result once taken, unless the emit state reloads it
      if (m_valid_q && m_axis_tready_i && (state_q != S_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && gen_ok) begin
            i_q     <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            len_q      <= len_init;
            src_ctrl_q <= 1'b1;
            state_q    <= S_RS0;
          end
        end
        S_RS0: state_q <= S_RS1;
        S_RS1: begin
          // a single point is its own curve
          if (len_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_RS2;
          end
        end
        S_RS2: begin
          k_q     <= '0;
          state_q <= S_MX;
        end
        S_MX: state_q <= S_MY;
        S_MY: state_q <= S_WR;
        S_WR: begin
          if (k_q == len_q - IdxW'(1)) begin
            if (len_q == IdxW'(1)) begin
              state_q <= S_EMIT;
            end else begin
              len_q      <= len_q - IdxW'(1);
              src_ctrl_q <= 1'b0;
              state_q    <= S_RS0;
            end
          end else begin
            k_q     <= k_q + IdxW'(1);
            state_q <= S_MX;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= last_pt;
            if (last_pt) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + SegW'(1);
              state_q <= S_DIV;
            end
          end else begin
            m_valid_q <= m_valid_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Operand, product and result registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_DIV: begin
        if (div_rsp.done) begin
          t_q <= div_rsp.quot;
        end
      end
      S_RS1: begin
        a_q   <= rdata;
        res_q <= rdata;
      end
      S_RS2: b_q <= rdata;
      S_MX:  prod_q <= mul;
      S_MY: begin
        prod_q <= mul;
        rx_q   <= lerp;
      end
      S_WR: begin
        a_q   <= b_q;
        b_q   <= rdata;
        res_q <= {lerp, rx_q};
      end
      S_EMIT: begin
        if (out_free) begin
          m_data_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // The divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the wait state");

  // The scratch write stays inside the current round
  a_wr_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> k_q < len_q)
    else $error("lerp index beyond the round length");

  // A lerp only runs when the round has work
  a_mul_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MX |-> len_q != '0)
    else $error("multiply started in an empty round");

  // A new result appears only out of the emit state
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_valid_q ##1 m_valid_q |-> $past(state_q == S_EMIT))
    else $error("output loaded outside the emit state");

endmodule

`default_nettype wire

>>> sv/bct_div.sv
// Bit-serial restoring divider giving t = (i << 16) / segments, one quotient bit a cycle.
// Depends on bct_pkg.
`default_nettype none

module bct_div (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  bct_pkg::div_req_t  req_i,
  output bct_pkg::div_rsp_t  rsp_o
);
  import bct_pkg::*;

  localparam int DcW = $clog2(DivW + 1);

  logic            busy_q;
  logic            done_q;
  logic [DcW-1:0]  cnt_q;
  logic [DivW-1:0] acc_q;   // dividend bits shift out, quotient bits shift in
  logic [SegW-1:0] rem_q;
  logic [SegW-1:0] den_q;

  logic [SegW:0]   trial;
  logic [SegW:0]   diff;
  logic            fits;
  logic [SegW-1:0] rem_d;

  // One restoring step: bring down the next dividend bit and try the divisor
  always_comb begin
    trial = {rem_q, acc_q[DivW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? diff[SegW-1:0] : trial[SegW-1:0];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DcW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DcW'(1);
        if (cnt_q == DcW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= {req_i.num, FracW'(0)};
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      acc_q <= {acc_q[DivW-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q[TW-1:0];

endmodule

`default_nettype wire

>>> tb/bezier_curve_tessellator_tb.sv
// Testbench for bezier_curve_tessellator: drives write and generate requests plus register
// writes, predicts every curve point by de Casteljau in Q1.16 and checks each result.
// Depends on bct_pkg and the bezier_curve_tessellator RTL.
module bezier_curve_tessellator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bct_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int MaxPoints   = 16;
  localparam int StallLimit  = 4000;  // cycles with no handshake at all
  localparam int DrainCycles = 400;

  typedef enum logic {
    ActWrite    = 1'b0,
    ActGenerate = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegNumPoints = 2'd0,
    RegSegments  = 2'd1,
    RegSpare2    = 2'd2,
    RegSpare3    = 2'd3
  } reg_idx_e;

  typedef struct {
    action_e                   action;
    logic [IdxInW-1:0]         idx;
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
  } tess_req_t;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
  } curve_pt_t;

  // DUT connections
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i     = '0;
  logic [CfgDataW-1:0]   cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i  = '0;
  logic [0:0]            s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  // Predictor state
  logic signed [CoordW-1:0] ctrl_x [MaxPoints];
  logic signed [CoordW-1:0] ctrl_y [MaxPoints];
  logic [NptW-1:0]          num_points_r = '0;
  logic [SegW-1:0]          segments_r   = '0;

  tess_req_t req_q [$];
  tess_req_t req_cur;
  bit        req_pending = 1'b0;
  curve_pt_t curve_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  bezier_curve_tessellator #(
    .MAX_POINTS(MaxPoints)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // One lerp step: a + floor((t*(b-a) + half) / 2^16)
  function automatic logic signed [CoordW-1:0] lerp_q16(input logic signed [CoordW-1:0] a,
                                                        input logic signed [CoordW-1:0] b,
                                                        input logic [TW-1:0] t);
    longint prod;
    prod = longint'(t) * (longint'(b) - longint'(a)) + 32768;
    return CoordW'(longint'(a) + (prod >>> FracW));
  endfunction

  // Store a control point, or queue the curve points a generate request yields
  task automatic predict_curve(input tess_req_t req);
    logic signed [CoordW-1:0] wx [MaxPoints];
    logic signed [CoordW-1:0] wy [MaxPoints];
    logic [TW-1:0]            t;
    int                       n;
    int                       seg;
    curve_pt_t                pt;
    if (req.action == ActWrite) begin
      ctrl_x[req.idx] = req.x;
      ctrl_y[req.idx] = req.y;
    end else begin
      n   = (num_points_r > MaxPoints) ? MaxPoints : int'(num_points_r);
      seg = int'(segments_r);
      if (n != 0 && seg != 0) begin
        for (int i = 0; i <= seg; i++) begin
          t  = TW'((i * 65536) / seg);
          wx = ctrl_x;
          wy = ctrl_y;
          for (int r = 1; r < n; r++) begin
            for (int k = 0; k + r < n; k++) begin
              wx[k] = lerp_q16(wx[k], wx[k+1], t);
              wy[k] = lerp_q16(wy[k], wy[k+1], t);
            end
          end
          pt.x    = wx[0];
          pt.y    = wy[0];
          pt.last = (i == seg);
          curve_q.push_back(pt);
        end
      end
    end
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Present the next request; hold it until the handshake completes
  always @(negedge clk_i) begin
    if (rst_ni && !req_pending) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_cur          = req_q.pop_front();
        req_pending      = 1'b1;
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {{(InDataW - IdxInW - 2*CoordW){1'b0}}, req_cur.y, req_cur.x,
                            req_cur.idx};
        s_axis_tuser_i  <= req_cur.action;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Throttle the curve point stream
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on accepted requests, check curve points, watch for a hang
  always @(posedge clk_i) begin : sample
    bit                       fired;
    curve_pt_t                exp_pt;
    logic signed [CoordW-1:0] got_x;
    logic signed [CoordW-1:0] got_y;
    fired = 1'b0;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predict_curve(req_cur);
      req_pending = 1'b0;
      fired       = 1'b1;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      fired = 1'b1;
      got_x = m_axis_tdata_o[CoordW-1:0];
      got_y = m_axis_tdata_o[2*CoordW-1:CoordW];
      if (curve_q.size() == 0) begin
        report($sformatf("unexpected curve point x=%0d y=%0d last=%0b",
                         got_x, got_y, m_axis_tlast_o));
      end else begin
        exp_pt = curve_q.pop_front();
        if (got_x !== exp_pt.x)
          report($sformatf("curve_x mismatch: expected %0d, got %0d", exp_pt.x, got_x));
        if (got_y !== exp_pt.y)
          report($sformatf("curve_y mismatch: expected %0d, got %0d", exp_pt.y, got_y));
        if (m_axis_tlast_o !== exp_pt.last)
          report($sformatf("last mismatch: expected %0b, got %0b", exp_pt.last,
                           m_axis_tlast_o));
      end
    end
    if (cfg_valid_i && cfg_ready_o) fired = 1'b1;
    if (!rst_ni || fired) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("bezier_curve_tessellator_tb: errors");
        $finish;
      end
    end
  end

  // Write one register; only called while the block is idle
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegNumPoints: num_points_r = data[NptW-1:0];
      RegSegments:  segments_r   = data[SegW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_write(input int idx, input int x, input int y);
    tess_req_t req;
    req.action = ActWrite;
    req.idx    = IdxInW'(idx);
    req.x      = CoordW'(x);
    req.y      = CoordW'(y);
    req_q.push_back(req);
  endtask

  task automatic push_generate();
    tess_req_t req;
    req.action = ActGenerate;
    req.idx    = IdxInW'($urandom);
    req.x      = CoordW'($urandom);
    req.y      = CoordW'($urandom);
    req_q.push_back(req);
  endtask

  // Coordinates with the extremes mixed in
  function automatic int rand_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return -32768;
    if (roll < 16) return 32767;
    if (roll < 20) return 0;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Wait until every request is taken and every curve point has arrived
  task automatic drain();
    do @(posedge clk_i); while (req_q.size() != 0 || req_pending || curve_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random settings per pass, mostly small sizes, then a burst of requests
  task automatic run_phase(input int send_pct, input int recv_pct);
    int roll;
    int n;
    int s;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (2) begin
      roll = $urandom_range(99);
      n = (roll < 5) ? 0 : (roll < 75) ? $urandom_range(4, 1) :
          (roll < 90) ? $urandom_range(16, 5) : $urandom_range(31, 17);
      roll = $urandom_range(99);
      s = (roll < 5) ? 0 : (roll < 75) ? $urandom_range(6, 1) :
          (roll < 95) ? $urandom_range(20, 7) : $urandom_range(63, 21);
      write_reg(RegNumPoints, {3'($urandom), 5'(n)});
      write_reg(RegSegments, {2'($urandom), 6'(s)});
      if ($urandom_range(3) == 0) write_reg(reg_idx_e'($urandom_range(3, 2)), 8'($urandom));
      repeat (10) begin
        if ($urandom_range(99) < 40) push_generate();
        else push_write($urandom_range(15), rand_coord(), rand_coord());
      end
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Generate with registers at reset, then fill every slot starting with the extremes
    push_generate();
    for (int k = 0; k < MaxPoints; k++) begin
      push_write(k, (k == 0) ? -32768 : (k == 1) ? 32767 : rand_coord(),
                 (k == 0) ? 32767 : (k == 1) ? -32768 : rand_coord());
    end
    drain();
    // Zero points with segments set
    write_reg(RegSegments, 8'd5);
    push_generate();
    drain();
    // Single point: every output equals slot 0
    write_reg(RegNumPoints, 8'd1);
    push_generate();
    drain();
    // Zero segments
    write_reg(RegNumPoints, 8'd2);
    write_reg(RegSegments, 8'd0);
    push_generate();
    drain();
    // Largest curve
    write_reg(RegNumPoints, 8'd16);
    write_reg(RegSegments, 8'd63);
    push_generate();
    drain();
    // Point count above the store clamps; unused indexes and upper data bits are dropped
    write_reg(RegNumPoints, 8'hFF);
    write_reg(RegSegments, 8'hC3);
    write_reg(RegSpare2, 8'hFF);
    write_reg(RegSpare3, 8'hA5);
    push_generate();
    drain();
    // One segment: t at zero and at one
    write_reg(RegNumPoints, 8'd16);
    write_reg(RegSegments, 8'd1);
    push_generate();
    drain();

    run_phase(0, 0);
    run_phase(61, 0);
    run_phase(0, 61);
    run_phase(24, 24);

    if (mismatches == 0) begin
      $display("bezier_curve_tessellator_tb: clean");
    end else begin
      $display("bezier_curve_tessellator_tb: errors");
    end
    $finish;
  end

endmodule
